// ----- design/crgm_pkg.sv -----
`default_nettype none
package crgm_pkg;

	localparam int MAX_BLOCKS_DEF = 256;
	localparam int QDEPTH = 2;

	typedef struct packed {
		logic        mode;
		logic        strand_minus;
		logic [31:0] query_start;
		logic [31:0] query_end;
		logic [31:0] target_end;
		logic [31:0] coding_start;
		logic [31:0] coding_end;
		logic [31:0] block_size;
		logic [31:0] block_query_start;
		logic [31:0] block_target_start;
		logic        last_block;
	} item_t;

	typedef struct packed {
		logic [31:0] genome_coding_start;
		logic [31:0] genome_coding_end;
		logic        fell_back;
		logic        overflow;
	} result_t;

	typedef enum logic [1:0] {
		OP_HEADER,
		OP_BLOCK,
		OP_LAST
	} op_t;

	typedef struct packed {
		op_t   op;
		item_t item;
	} qentry_t;

	typedef struct packed {
		logic        minus;
		logic [31:0] qstart;
		logic [31:0] qend;
		logic [31:0] tend;
		logic [31:0] cstart;
		logic [31:0] cend;
	} header_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_DAT,
		S_APP,
		S_CMP,
		S_DONE
	} bstate_t;

endpackage
`default_nettype wire

// ----- design/crgm_ram.sv -----
`default_nettype none
module crgm_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- design/crgm_front.sv -----
`default_nettype none
module crgm_front
	import crgm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire item_t   item,
	output logic         q_valid,
	output qentry_t      q_entry,
	input  wire logic    q_pop
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	qentry_t        entries_q [QDEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           push;
	qentry_t        new_entry;

	assign busy    = (cnt_q == CW'(QDEPTH));
	assign push    = start && !busy;
	assign q_valid = (cnt_q != '0);
	assign q_entry = entries_q[rd_ptr_q];

	// classify the beat for the back end
	always_comb begin
		new_entry.item = item;
		if (!item.mode) begin
			new_entry.op = OP_HEADER;
		end else if (item.last_block) begin
			new_entry.op = OP_LAST;
		end else begin
			new_entry.op = OP_BLOCK;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop && q_valid) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !(q_pop && q_valid)) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop && q_valid) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/crgm_back.sv -----
`default_nettype none
module crgm_back
	import crgm_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    q_valid,
	input  wire qentry_t q_entry,
	output logic         q_pop,
	output logic         done,
	output result_t      result
);

	localparam int AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW    = $clog2(MAX_BLOCKS + 1);
	localparam int OFF_W = 36 + AW;
	localparam int GAP_W = 35;

	function automatic logic signed [OFF_W-1:0] zx(input logic [31:0] v);
		return $signed({{(OFF_W-32){1'b0}}, v});
	endfunction

	function automatic logic signed [GAP_W-1:0] gx(input logic [31:0] v);
		return $signed({{(GAP_W-32){1'b0}}, v});
	endfunction

	bstate_t state_q, state_d;
	header_t hdr_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] idx_q;
	logic          bwd_q;
	logic          first_q;
	logic          got_s_q;
	logic          got_e_q;
	logic signed [OFF_W-1:0] off_q;
	logic signed [OFF_W-1:0] eoff_q;
	logic signed [GAP_W-1:0] gap_q;
	logic [31:0] cur_sz_q, cur_qs_q, cur_ts_q;
	logic [31:0] prev_sz_q, prev_qs_q;
	logic [31:0] gs_q, ge_q;
	logic        done_q;
	result_t     result_q;

	logic          ram_we;
	logic [95:0]   ram_rdata;
	logic          has_room;
	logic [CW-1:0] n_next;
	logic          is_last;
	logic signed [OFF_W-1:0] a_off, b_off, app_off;
	logic          found;
	logic          more_fwd;

	crgm_ram #(
		.WIDTH (96),
		.DEPTH (MAX_BLOCKS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata ({q_entry.item.block_target_start, q_entry.item.block_query_start,
		         q_entry.item.block_size}),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign has_room = (count_q < CW'(MAX_BLOCKS));
	assign n_next   = has_room ? count_q + 1'b1 : count_q;
	assign is_last  = (q_entry.op == OP_LAST);
	assign a_off    = zx(hdr_q.cstart) - zx(hdr_q.qstart);
	assign b_off    = zx(hdr_q.qend) - zx(hdr_q.cend);
	assign app_off  = first_q ? off_q : off_q - OFF_W'(gap_q);
	assign found    = (off_q < zx(cur_sz_q));
	assign more_fwd = ((idx_q + 1'b1) < n_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (q_valid && is_last) begin
					state_d = (n_next == '0) ? S_DONE : S_RD;
				end
			end
			S_RD:  state_d = S_DAT;
			S_DAT: state_d = S_APP;
			S_APP: state_d = S_CMP;
			S_CMP: begin
				if (!bwd_q) begin
					state_d = S_RD;
				end else if (found || idx_q == '0) begin
					state_d = S_DONE;
				end else begin
					state_d = S_RD;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop  = 1'b0;
		ram_we = 1'b0;
		case (state_q)
			S_IDLE: begin
				q_pop  = q_valid;
				ram_we = q_valid && (q_entry.op != OP_HEADER) && has_room;
			end
			default: begin
				q_pop  = 1'b0;
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hdr_q   <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_DONE);
			if (state_q == S_IDLE && q_valid) begin
				if (q_entry.op == OP_HEADER) begin
					hdr_q.minus  <= q_entry.item.strand_minus;
					hdr_q.qstart <= q_entry.item.query_start;
					hdr_q.qend   <= q_entry.item.query_end;
					hdr_q.tend   <= q_entry.item.target_end;
					hdr_q.cstart <= q_entry.item.coding_start;
					hdr_q.cend   <= q_entry.item.coding_end;
					count_q      <= '0;
					ovf_q        <= 1'b0;
				end else if (has_room) begin
					count_q <= count_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == S_DONE) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid && is_last) begin
					n_q     <= n_next;
					idx_q   <= '0;
					bwd_q   <= 1'b0;
					first_q <= 1'b1;
					got_s_q <= 1'b0;
					got_e_q <= 1'b0;
					off_q   <= hdr_q.minus ? b_off : a_off;
					eoff_q  <= hdr_q.minus ? a_off : b_off;
				end
			end
			S_DAT: begin
				cur_sz_q <= ram_rdata[31:0];
				cur_qs_q <= ram_rdata[63:32];
				cur_ts_q <= ram_rdata[95:64];
				// unaligned transcript gap between this block and the one walked before
				if (!bwd_q) begin
					gap_q <= gx(ram_rdata[63:32]) - gx(prev_qs_q) - gx(prev_sz_q);
				end else begin
					gap_q <= gx(prev_qs_q) - gx(ram_rdata[63:32]) - gx(ram_rdata[31:0]);
				end
			end
			S_APP: begin
				off_q <= (app_off < 0) ? '0 : app_off;
			end
			S_CMP: begin
				prev_sz_q <= cur_sz_q;
				prev_qs_q <= cur_qs_q;
				first_q   <= 1'b0;
				off_q     <= off_q - zx(cur_sz_q);
				if (!bwd_q) begin
					if (found) begin
						gs_q    <= cur_ts_q + off_q[31:0];
						got_s_q <= 1'b1;
					end
					if (found || !more_fwd) begin
						bwd_q   <= 1'b1;
						first_q <= 1'b1;
						idx_q   <= n_q - 1'b1;
						off_q   <= eoff_q;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end else begin
					if (found) begin
						ge_q    <= cur_ts_q + (cur_sz_q - off_q[31:0]);
						got_e_q <= 1'b1;
					end else if (idx_q != '0) begin
						idx_q <= idx_q - 1'b1;
					end
				end
			end
			S_DONE: begin
				if (got_s_q && got_e_q) begin
					result_q.genome_coding_start <= gs_q;
					result_q.genome_coding_end   <= ge_q;
					result_q.fell_back           <= 1'b0;
				end else begin
					result_q.genome_coding_start <= hdr_q.tend;
					result_q.genome_coding_end   <= hdr_q.tend;
					result_q.fell_back           <= 1'b1;
				end
				result_q.overflow <= ovf_q;
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// ----- design/coding_region_to_genome_mapper.sv -----
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+----------------
// item      | in        | beat when start && !busy  | item_t
// result    | out       | one-cycle strobe on done  | result_t
//
// a two-entry queue takes a beat in every cycle until it is full; busy is queue full.
// idle pops each beat: a header loads the header registers, a block makes one store
// write (or, with no room, sets overflow); a final block then walks forward and back,
// each visited block taking ram read, gap, clamp, compare; done is then registered.
// reset clears header registers, block count, overflow flag, queue and walker state.
// results are never stalled: done is high for exactly one cycle per final block.
`default_nettype none
module coding_region_to_genome_mapper
	import crgm_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	output logic       busy,
	input  wire item_t item,
	output logic       done,
	output result_t    result
);

	logic    q_valid;
	logic    q_pop;
	qentry_t q_entry;

	crgm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop)
	);

	crgm_back #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop),
		.done    (done),
		.result  (result)
	);

endmodule
`default_nettype wire
